@@ rtl/deque_with_search_top_assert.svh @@
// ----------------------------------------------------------------------------
// deque_with_search_top_assert.svh
// Assertion macros shared by the deque checker.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled in reset
`define DWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/dws_pkg.sv @@
// ----------------------------------------------------------------------------
// dws_pkg
// Types and constants for the deque with search.
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        K_INS_FRONT = 3'd0,
        K_INS_BACK  = 3'd1,
        K_REM_FRONT = 3'd2,
        K_REM_BACK  = 3'd3,
        K_SEARCH    = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic load;
        logic live;
    } t_cell_ctl;

endpackage

@@ rtl/deque_with_search_top.sv @@
// Latency: a result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle while i_ready does not stall the output; the cell row
// updates on each accepted item and one output register holds the result while the next item is taken.
// Reset (synchronous, active low) empties the deque and clears the output valid flag.
// ----------------------------------------------------------------------------
// deque_with_search_top
// Bounded deque as a row of shift cells, with a parallel value search.
// ----------------------------------------------------------------------------
module deque_with_search_top
    import dws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic               o_found,
    output logic [ECNT_W-1:0]  o_entry_count
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic              n_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic              r_found;
    logic              n_found;

    logic              acc;
    logic              full;
    logic              empty;
    logic              do_shift_r;
    logic              do_shift_l;
    logic              do_load;
    logic [DATA_W-1:0] value;
    logic [DEPTH-1:0]  match;
    logic [DATA_W-1:0] data [DEPTH];
    t_cell_ctl         ctl  [DEPTH];

    assign o_ready = !r_out_valid || i_ready;
    assign acc     = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign value   = i_value[DATA_W-1:0];

    always_comb begin
        n_count    = r_count;
        n_status   = ST_DONE;
        n_found    = 1'b0;
        do_shift_r = 1'b0;
        do_shift_l = 1'b0;
        do_load    = 1'b0;
        case (t_kind'(i_kind))
            K_INS_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_shift_r = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end
            K_INS_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_load = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            K_REM_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_shift_l = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            K_REM_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            K_SEARCH: begin
                n_found = |match;
            end
            default: begin
            end
        endcase
        n_out_valid = acc || (r_out_valid && !i_ready);
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            always_comb begin
                ctl[g].shift_r = acc && do_shift_r;
                ctl[g].shift_l = acc && do_shift_l;
                ctl[g].load    = acc && do_load && (CNT_W'(g) == r_count);
                ctl[g].live    = (CNT_W'(g) < r_count);
            end

            dws_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl[g]),
                .i_value      (value),
                .i_from_front ((g == 0) ? value : data[(g == 0) ? 0 : g - 1]),
                .i_from_back  ((g == DEPTH - 1) ? data[g]
                                                : data[(g == DEPTH - 1) ? g : g + 1]),
                .o_data       (data[g]),
                .o_match      (match[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (acc) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_entry_count = ECNT_W'(r_count);

endmodule

@@ rtl/dws_cell.sv @@
// ----------------------------------------------------------------------------
// dws_cell
// One deque position: holds a word, shifts toward either neighbor, compares.
// ----------------------------------------------------------------------------
module dws_cell
    import dws_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_from_front,
    input  logic [DATA_W-1:0] i_from_back,
    output logic [DATA_W-1:0] o_data,
    output logic              o_match
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_r) begin
            n_data = i_from_front;
        end else if (i_ctl.shift_l) begin
            n_data = i_from_back;
        end else if (i_ctl.load) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = i_ctl.live && (r_data == i_value);

endmodule

@@ rtl/dws_checker.sv @@
// ----------------------------------------------------------------------------
// dws_checker
// Port-level checks for the deque with search, bound to the top level.
// ----------------------------------------------------------------------------
`include "deque_with_search_top_assert.svh"

module dws_checker
    import dws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [STAT_W-1:0]  o_status,
    input  logic               o_found,
    input  logic [ECNT_W-1:0]  o_entry_count
);

    `DWS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_valid && o_ready, o_valid)
    `DWS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_status) && $stable(o_found) && $stable(o_entry_count))
    `DWS_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_valid && (o_status == ST_FULL),
        o_entry_count == ECNT_W'(DEPTH))
    `DWS_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY),
        o_entry_count == '0)
    `DWS_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, o_valid && o_found,
        (o_status == ST_DONE) && (o_entry_count != '0))

endmodule

bind deque_with_search_top dws_checker u_dws_checker (.*);
